/* src/h3pri_pkg.sv */
package h3pri_pkg;

	// parse phases of the frame walker
	typedef enum logic [1:0] {
		PH_TYPE   = 2'd0,
		PH_VINT   = 2'd1,
		PH_WEIGHT = 2'd2
	} parse_phase_t;

	// type code meaning current stream (element) or root (dependency)
	localparam logic [1:0] TYPE_SPECIAL = 2'd3;

	localparam int unsigned ID_W = 62;

	// varint length prefix to bytes still due after the first byte
	function automatic logic [2:0] vint_extra(input logic [1:0] prefix);
		logic [2:0] n;
		unique case (prefix)
			2'd0: n = 3'd0;
			2'd1: n = 3'd1;
			2'd2: n = 3'd3;
			2'd3: n = 3'd7;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

/* src/http3_priority_frame_parser.sv */
// Parser for an HTTP/3 draft PRIORITY frame payload, fed one byte per transfer. The first
// byte of a frame (or any byte with frame_start set) is the type byte; then come up to two
// QUIC varints (element id, dependency id) and the weight byte. Every byte yields one result
// carrying the types and ids decoded so far; done_res marks the weight byte, after which the
// parser expects a new type byte. Each byte passes the input register, then the result register;
// one byte is taken per cycle while byte_stall is low, set by the single shift-accumulate and
// phase update per byte. The result register holds while result_stall is high, and byte_stall
// rises only when the input and result registers are both full and the result is stalled.
module http3_priority_frame_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        byte_valid,
	output logic                        byte_stall,
	input  logic                        frame_start,
	input  logic [7:0]                  data_byte,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic                        done_res,
	output logic [1:0]                  element_type,
	output logic [1:0]                  dependency_type,
	output logic [h3pri_pkg::ID_W-1:0]  element_id,
	output logic [h3pri_pkg::ID_W-1:0]  dependency_id,
	output logic [7:0]                  weight
);
	import h3pri_pkg::*;

	// input register
	logic              valid_s1;
	logic              start_s1;
	logic [7:0]        byte_s1;

	// parser state; held fields double as the result register
	parse_phase_t      phase_q, phase_nxt;
	logic [2:0]        left_q, left_nxt;
	logic [ID_W-1:0]   acc_q, acc_nxt;
	logic              have_elem_q, have_elem_nxt;
	logic [1:0]        elem_type_q, elem_type_nxt;
	logic [1:0]        dep_type_q, dep_type_nxt;
	logic [ID_W-1:0]   elem_id_q, elem_id_nxt;
	logic [ID_W-1:0]   dep_id_q, dep_id_nxt;
	logic              done_q, done_nxt;
	logic [7:0]        weight_q, weight_nxt;
	logic              out_valid_q;

	logic              advance;
	logic              restart;
	logic              vint_first;
	logic              vint_done;
	logic              to_dep;
	logic [2:0]        left_step;
	logic [ID_W-1:0]   acc_step;

	// handshake: the step fires when the result register is free or being drained
	assign advance    = valid_s1 && (!out_valid_q || !result_stall);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			start_s1 <= frame_start;
			byte_s1  <= data_byte;
		end
	end

	// shared step terms
	assign restart    = start_s1 || (phase_q != PH_VINT && phase_q != PH_WEIGHT);
	assign vint_first = (left_q == 3'd0);
	assign left_step  = vint_first ? vint_extra(byte_s1[7:6]) : left_q - 3'd1;
	assign acc_step   = vint_first ? {{(ID_W-6){1'b0}}, byte_s1[5:0]}
	                               : {acc_q[ID_W-9:0], byte_s1};
	assign vint_done  = (left_step == 3'd0);
	assign to_dep     = (elem_type_q == TYPE_SPECIAL) || have_elem_q;

	// next phase
	always_comb begin
		phase_nxt = phase_q;
		if (restart) begin
			if (byte_s1[7:6] == TYPE_SPECIAL && byte_s1[5:4] == TYPE_SPECIAL) begin
				phase_nxt = PH_WEIGHT;
			end else begin
				phase_nxt = PH_VINT;
			end
		end else if (phase_q == PH_VINT) begin
			if (vint_done && (to_dep || dep_type_q == TYPE_SPECIAL)) begin
				phase_nxt = PH_WEIGHT;
			end
		end else begin
			phase_nxt = PH_TYPE;
		end
	end

	// datapath and result fields
	always_comb begin
		left_nxt      = left_q;
		acc_nxt       = acc_q;
		have_elem_nxt = have_elem_q;
		elem_type_nxt = elem_type_q;
		dep_type_nxt  = dep_type_q;
		elem_id_nxt   = elem_id_q;
		dep_id_nxt    = dep_id_q;
		done_nxt      = 1'b0;
		weight_nxt    = 8'd0;
		if (restart) begin
			elem_type_nxt = byte_s1[7:6];
			dep_type_nxt  = byte_s1[5:4];
			elem_id_nxt   = '0;
			dep_id_nxt    = '0;
			have_elem_nxt = 1'b0;
			left_nxt      = 3'd0;
			acc_nxt       = '0;
		end else if (phase_q == PH_VINT) begin
			if (vint_done) begin
				left_nxt = 3'd0;
				acc_nxt  = '0;
				if (to_dep) begin
					dep_id_nxt = acc_step;
				end else begin
					elem_id_nxt   = acc_step;
					have_elem_nxt = 1'b1;
				end
			end else begin
				left_nxt = left_step;
				acc_nxt  = acc_step;
			end
		end else begin
			done_nxt   = 1'b1;
			weight_nxt = byte_s1;
		end
	end

	// state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TYPE;
			left_q      <= 3'd0;
			acc_q       <= '0;
			have_elem_q <= 1'b0;
			elem_type_q <= 2'd0;
			dep_type_q  <= 2'd0;
			elem_id_q   <= '0;
			dep_id_q    <= '0;
			done_q      <= 1'b0;
			weight_q    <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q     <= phase_nxt;
				left_q      <= left_nxt;
				acc_q       <= acc_nxt;
				have_elem_q <= have_elem_nxt;
				elem_type_q <= elem_type_nxt;
				dep_type_q  <= dep_type_nxt;
				elem_id_q   <= elem_id_nxt;
				dep_id_q    <= dep_id_nxt;
				done_q      <= done_nxt;
				weight_q    <= weight_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid    = out_valid_q;
	assign done_res        = done_q;
	assign element_type    = elem_type_q;
	assign dependency_type = dep_type_q;
	assign element_id      = elem_id_q;
	assign dependency_id   = dep_id_q;
	assign weight          = weight_q;

	// a finished frame leaves the parser waiting for a type byte with no partial varint
	a_done_resets_phase: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (phase_q == PH_TYPE && left_q == 3'd0))
		else $error("phase not back to type after done");

	// weight only appears on the done result
	a_weight_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(weight_q != 8'd0) |-> done_q)
		else $error("weight set without done");

	// element id stays zero until it has been decoded
	a_elem_id_gated: assert property (@(posedge clk) disable iff (!arst_n)
		!have_elem_q |-> (elem_id_q == '0))
		else $error("element id set before decode");

	// the input stalls only behind a full input register
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && out_valid_q))
		else $error("stall without held item");

endmodule
